### rtl/pbsm_pkg.sv
// Package for the pressure to blower speed map.
// Holds the segment thresholds, divisor constants and the request type between
// the front stages and the divider stages. No dependencies.
`default_nettype none

package pbsm_pkg;

    localparam int NUM_CAL     = 6;
    localparam int CAL_W       = 16;
    localparam int PRESSURE_W  = 16;
    localparam int SPEED_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int SEG_W       = 3;
    localparam int ANCHOR_W    = 12;
    localparam int MUL_A_W     = 18;
    localparam int MUL_B_W     = 17;
    localparam int PROD_W      = 35;
    localparam int BASE_W      = 25;
    localparam int SUM_W       = 36;
    localparam int X_W         = 24;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int QEST_W      = 18;
    localparam int DIVQ_W      = 8;

    localparam int SEG_DIV     = 500;
    localparam int SEG0_DIV    = 900;
    localparam int SEG0_OFFSET = 400;
    localparam int SPEED_MAX   = 65535;

    typedef logic [CAL_W-1:0]     cal_t;
    typedef logic [SEG_W-1:0]     seg_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam logic [PRESSURE_W-1:0] SEG_THRESH [NUM_CAL-1] =
        '{16'd510, 16'd1010, 16'd1510, 16'd2010, 16'd2510};

    localparam logic signed [SUM_W-1:0] SUM_NEG_LIMIT = -36'sd500;
    localparam logic signed [SUM_W-1:0] SUM_OVER_SEG  = 36'((SPEED_MAX + 1) * SEG_DIV);
    localparam logic signed [SUM_W-1:0] SUM_OVER_SEG0 = 36'((SPEED_MAX + 1) * SEG0_DIV);

    // The low two bits of the numerator are dropped, so the remaining divisors are a quarter.
    localparam logic [DIVQ_W-1:0]  DIVQ_SEG   = 8'(SEG_DIV / 4);
    localparam logic [DIVQ_W-1:0]  DIVQ_SEG0  = 8'(SEG0_DIV / 4);
    localparam logic [RECIP_W-1:0] RECIP_SEG  = 26'((64'd1 << RECIP_SHIFT) / (SEG_DIV / 4));
    localparam logic [RECIP_W-1:0] RECIP_SEG0 = 26'((64'd1 << RECIP_SHIFT) / (SEG0_DIV / 4));

    typedef struct packed {
        logic [X_W-1:0] x;
        logic           seg0;
        logic           neg;
        logic           over;
    } quot_req_t;

endpackage

`default_nettype wire

### rtl/pbsm_in_if.sv
// Request channel of the pressure to blower speed map.
// Carries one pressure sample per request; depends on pbsm_pkg.
`default_nettype none

interface pbsm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [pbsm_pkg::PRESSURE_W-1:0]      pressure;

    modport source (output valid, output pressure, input ready);
    modport sink   (input valid, input pressure, output ready);
endinterface

`default_nettype wire

### rtl/pbsm_out_if.sv
// Result channel of the pressure to blower speed map.
// Carries the speed and the saturation flag; depends on pbsm_pkg.
`default_nettype none

interface pbsm_out_if;
    logic                              valid;
    logic                              ready;
    logic [pbsm_pkg::SPEED_W-1:0]      speed;
    logic                              saturated;

    modport source (output valid, output speed, output saturated, input ready);
    modport sink   (input valid, input speed, input saturated, output ready);
endinterface

`default_nettype wire

### rtl/pbsm_div_stage.sv
// Divider stages: reciprocal multiply, one-step correction and saturation.
// Drives the result channel; depends on pbsm_pkg and pbsm_out_if.
`default_nettype none

module pbsm_div_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    input  pbsm_pkg::quot_req_t  req,
    output logic                 req_ready,
    pbsm_out_if.source           rsp
);
    import pbsm_pkg::*;

    logic                 en4;
    logic                 en5;
    logic                 s4_valid_reg;
    quot_req_t            s4_req_reg;
    logic [QEST_W-1:0]    s4_qest_reg;
    logic [QEST_W-1:0]    qest_next;
    logic [RECIP_W-1:0]   recip;
    logic [49:0]          recip_prod;
    logic [DIVQ_W-1:0]    divq;
    logic [RECIP_W-1:0]   qd;
    logic [RECIP_W-1:0]   rem;
    logic [QEST_W-1:0]    quot;
    logic                 out_valid_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic                 sat_reg;
    logic [SPEED_W-1:0]   speed_next;
    logic                 sat_next;

    assign en5       = !out_valid_reg || rsp.ready;
    assign en4       = !s4_valid_reg || en5;
    assign req_ready = en4;

    always_comb
    begin
        recip      = req.seg0 ? RECIP_SEG0 : RECIP_SEG;
        recip_prod = 50'(req.x) * 50'(recip);
        qest_next  = recip_prod[49:RECIP_SHIFT];
    end

    always_comb
    begin
        divq = s4_req_reg.seg0 ? DIVQ_SEG0 : DIVQ_SEG;
        qd   = 26'(s4_qest_reg) * 26'(divq);
        rem  = 26'(s4_req_reg.x) - qd;
        quot = (rem >= 26'(divq)) ? s4_qest_reg + 18'd1 : s4_qest_reg;
        if (s4_req_reg.neg)
        begin
            speed_next = '0;
            sat_next   = 1'b1;
        end
        else if (s4_req_reg.over)
        begin
            speed_next = SPEED_W'(SPEED_MAX);
            sat_next   = 1'b1;
        end
        else
        begin
            speed_next = quot[SPEED_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                s4_valid_reg <= req_valid;
            end
            if (en5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_req_reg  <= req;
            s4_qest_reg <= qest_next;
        end
        if (en5)
        begin
            speed_reg <= speed_next;
            sat_reg   <= sat_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.speed     = speed_reg;
    assign rsp.saturated = sat_reg;

endmodule

`default_nettype wire

### rtl/pressure_to_blower_speed_map_top.sv
// Pressure to blower speed map: calibration registers, segment selection and
// the numerator stages. Depends on pbsm_pkg, pbsm_in_if, pbsm_out_if and pbsm_div_stage.
//
// Usage: a pressure request enters on the sample channel (valid/ready) and one
// result leaves on the result channel with the speed and a saturation flag.
// The six calibration speeds are written through cfg_wr_en, cfg_index and
// cfg_data while no request is in flight; indexes above five are ignored.
// A request accepted on the sample channel passes through the registers s1, s2,
// s3, s4 and the output register before it shows as a valid result. Throughput is one
// request per cycle: five register stages, each holding at most one multiply, and the
// pipeline takes a new request every clock while the result is taken.
// When the receiver stalls, requests advance into empty stages until the
// pipeline is full, and only then does sample.ready fall; nothing is dropped or
// repeated. Reset clears all stage valid bits and sets the calibration speeds
// to zero.
`default_nettype none

module pressure_to_blower_speed_map_top (
    input  wire                          clk,
    input  wire                          rst_n,
    pbsm_in_if.sink                      sample,
    pbsm_out_if.source                   result,
    input  wire                          cfg_wr_en,
    input  wire [pbsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [pbsm_pkg::CAL_W-1:0]    cfg_data
);
    import pbsm_pkg::*;

    cal_t                       cal_reg [NUM_CAL];

    logic                       en1;
    logic                       en2;
    logic                       en3;
    logic                       div_ready;

    seg_t                       seg;
    cal_t                       cj;
    cal_t                       cp;
    logic [ANCHOR_W-1:0]        anchor;
    logic signed [MUL_A_W-1:0]  mul_a_next;
    logic signed [MUL_B_W-1:0]  mul_b_next;
    logic [BASE_W-1:0]          base_next;

    logic                       s1_valid_reg;
    logic                       s1_seg0_reg;
    logic signed [MUL_A_W-1:0]  s1_mul_a_reg;
    logic signed [MUL_B_W-1:0]  s1_mul_b_reg;
    logic [BASE_W-1:0]          s1_base_reg;

    logic                       s2_valid_reg;
    logic                       s2_seg0_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;
    logic [BASE_W-1:0]          s2_base_reg;

    logic signed [SUM_W-1:0]    sum;
    quot_req_t                  quot_next;
    logic                       s3_valid_reg;
    quot_req_t                  s3_req_reg;

    assign en3          = !s3_valid_reg || div_ready;
    assign en2          = !s2_valid_reg || en3;
    assign en1          = !s1_valid_reg || en2;
    assign sample.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CAL; i++)
            begin
                cal_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_CAL)))
        begin
            cal_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        seg = '0;
        for (int s = 0; s < NUM_CAL - 1; s++)
        begin
            if (sample.pressure >= SEG_THRESH[s])
            begin
                seg = seg + SEG_W'(1);
            end
        end
        case (seg)
            3'd1:
            begin
                cj = cal_reg[1];
                cp = cal_reg[0];
            end
            3'd2:
            begin
                cj = cal_reg[2];
                cp = cal_reg[1];
            end
            3'd3:
            begin
                cj = cal_reg[3];
                cp = cal_reg[2];
            end
            3'd4:
            begin
                cj = cal_reg[4];
                cp = cal_reg[3];
            end
            3'd5:
            begin
                cj = cal_reg[5];
                cp = cal_reg[4];
            end
            default:
            begin
                cj = cal_reg[0];
                cp = '0;
            end
        endcase
        anchor = ANCHOR_W'(SEG_DIV) * (ANCHOR_W'(seg) + ANCHOR_W'(1));
        if (seg == '0)
        begin
            mul_a_next = $signed(MUL_A_W'(cj));
            mul_b_next = $signed(MUL_B_W'(sample.pressure) + MUL_B_W'(SEG0_OFFSET));
            base_next  = '0;
        end
        else
        begin
            mul_a_next = $signed(MUL_A_W'(cj) - MUL_A_W'(cp));
            mul_b_next = $signed(MUL_B_W'(sample.pressure) - MUL_B_W'(anchor));
            base_next  = BASE_W'(cj) * BASE_W'(SEG_DIV);
        end
    end

    always_comb
    begin
        sum            = SUM_W'(s2_prod_reg) + $signed(SUM_W'(s2_base_reg));
        quot_next.x    = sum[SUM_W-1] ? '0 : sum[X_W+1:2];
        quot_next.seg0 = s2_seg0_reg;
        quot_next.neg  = sum <= SUM_NEG_LIMIT;
        quot_next.over = s2_seg0_reg ? (sum >= SUM_OVER_SEG0) : (sum >= SUM_OVER_SEG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_seg0_reg  <= (seg == '0);
            s1_mul_a_reg <= mul_a_next;
            s1_mul_b_reg <= mul_b_next;
            s1_base_reg  <= base_next;
        end
        if (en2)
        begin
            s2_seg0_reg <= s1_seg0_reg;
            s2_prod_reg <= PROD_W'(s1_mul_a_reg * s1_mul_b_reg);
            s2_base_reg <= s1_base_reg;
        end
        if (en3)
        begin
            s3_req_reg <= quot_next;
        end
    end

    pbsm_div_stage u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s3_valid_reg),
        .req       (s3_req_reg),
        .req_ready (div_ready),
        .rsp       (result)
    );

endmodule

`default_nettype wire

### rtl/pbsm_checker.sv
// Port-level checks for the pressure to blower speed map.
// Bound to pressure_to_blower_speed_map_top; depends on pbsm_pkg.
`default_nettype none

module pbsm_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           sample_ready,
    input wire                           result_valid,
    input wire                           result_ready,
    input wire [pbsm_pkg::SPEED_W-1:0]   result_speed,
    input wire                           result_saturated
);
    import pbsm_pkg::*;

    // No result may be shown while reset is held.
    a_reset_quiet : assert property (@(posedge clk) !rst_n && $past(!rst_n) |-> !result_valid)
        else $error("result valid during reset");

    // A result that is not taken stays unchanged.
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_speed)
            && $stable(result_saturated))
        else $error("stalled result changed");

    // A clamped result sits at one of the two limits.
    a_sat_limits : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_saturated |->
            result_speed == '0 || result_speed == SPEED_W'(SPEED_MAX))
        else $error("saturated result not at a limit");

    // Requests are only refused when the pipeline is full and the result is stalled.
    a_ready_back : assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("request refused with room in the pipeline");

endmodule

bind pressure_to_blower_speed_map_top pbsm_checker u_pbsm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_ready     (sample.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_speed     (result.speed),
    .result_saturated (result.saturated)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the pressure to blower speed map: drives pressure requests
// in bursts, stalls the result side and checks every speed and flag against a predictor.
// Depends on pbsm_pkg, pbsm_in_if, pbsm_out_if and pressure_to_blower_speed_map_top.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pbsm_pkg::*;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               saturated;
    } speed_result_t;

    localparam cfg_idx_t LAST_IDX     = '1;
    localparam int       IDLE_LIMIT   = 4000;
    localparam int       END_PAD      = 20;
    localparam int       REPORT_LIMIT = 10;

    localparam logic [PRESSURE_W-1:0] EDGE_PRESSURES [25] = '{
        16'd0, 16'd1, 16'd499, 16'd500, 16'd509, 16'd510, 16'd1009, 16'd1010,
        16'd1509, 16'd1510, 16'd2009, 16'd2010, 16'd2500, 16'd2501, 16'd2509,
        16'd2510, 16'd3000, 16'd3001, 16'd3499, 16'd3500, 16'd32768, 16'h5555,
        16'hAAAA, 16'd65534, 16'd65535
    };

    logic     clk;
    logic     rst_n;
    logic     cfg_wr_en;
    cfg_idx_t cfg_index;
    cal_t     cfg_data;

    pbsm_in_if  sample_ch ();
    pbsm_out_if result_ch ();

    pressure_to_blower_speed_map_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cal_t                    cal_speed [NUM_CAL];
    cal_t                    cal_plan [NUM_CAL];
    logic [PRESSURE_W-1:0]   pressure_backlog [$];
    speed_result_t           speed_expect [$];
    int                      mismatch_count;
    int                      burst_left;
    int                      gap_left;
    int                      stall_mode;
    int                      stall_cycle;
    int                      idle_cycles;

    function automatic speed_result_t map_pressure(logic [PRESSURE_W-1:0] p);
        longint        pv;
        longint        c_hi;
        longint        c_lo;
        longint        v;
        int            seg;
        speed_result_t r;
        pv = longint'({48'd0, p});
        seg = 0;
        while (seg < NUM_CAL - 1 && pv >= 510 + 500 * seg)
        begin
            seg++;
        end
        c_hi = longint'({48'd0, cal_speed[seg]});
        if (seg == 0)
        begin
            v = (SEG0_DIV * c_hi + (pv - 500) * c_hi) / SEG0_DIV;
        end
        else
        begin
            c_lo = longint'({48'd0, cal_speed[seg - 1]});
            v = (SEG_DIV * c_hi + (pv - 500 * (seg + 1)) * (c_hi - c_lo)) / SEG_DIV;
        end
        if (v < 0)
        begin
            r.speed = '0;
            r.saturated = 1'b1;
        end
        else if (v > SPEED_MAX)
        begin
            r.speed = '1;
            r.saturated = 1'b1;
        end
        else
        begin
            r.speed = SPEED_W'(v);
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [PRESSURE_W-1:0] pick_pressure();
        int k;
        k = $urandom_range(1, 5);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return PRESSURE_W'($urandom_range(0, 3600));
            6:                return PRESSURE_W'(500 * k + 7 + $urandom_range(0, 6));
            7:                return PRESSURE_W'(500 * (k + 1) - 3 + $urandom_range(0, 6));
            8:                return PRESSURE_W'($urandom_range(0, 65535));
            default:          return PRESSURE_W'($urandom_range(60000, 65535));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input speed_result_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("mismatch (%s): expected speed %0d saturated %0b, got speed %0d saturated %0b",
                     what, want.speed, want.saturated, result_ch.speed, result_ch.saturated);
        end
    endtask

    task automatic program_cal();
        int i;
        for (i = 0; i <= LAST_IDX; i++)
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            if (i < NUM_CAL)
            begin
                cfg_data <= cal_plan[i];
                cal_speed[i] = cal_plan[i];
            end
            else
            begin
                cfg_data <= cal_t'($urandom);
            end
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_plan();
        int i;
        int base;
        int step;
        int mode;
        mode = $urandom_range(0, 3);
        base = $urandom_range(0, 5000);
        step = $urandom_range(0, 12000);
        for (i = 0; i < NUM_CAL; i++)
        begin
            case (mode)
                0:       cal_plan[i] = cal_t'($urandom);
                1:       cal_plan[i] = cal_t'(base + i * step);
                2:       cal_plan[i] = cal_t'($urandom_range(0, 20));
                default: cal_plan[i] = ($urandom_range(0, 1) == 1) ? cal_t'($urandom_range(60000, 65535))
                                                                     : cal_t'($urandom_range(0, 3));
            endcase
        end
    endtask

    task automatic feed_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            pressure_backlog.push_back(pick_pressure());
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pressure_backlog.size() != 0 || sample_ch.valid || speed_expect.size() != 0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.pressure <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                speed_expect.push_back(map_pressure(sample_ch.pressure));
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (gap_left != 0 || pressure_backlog.size() == 0)
                begin
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                    sample_ch.valid <= 1'b0;
                    sample_ch.pressure <= PRESSURE_W'($urandom);
                end
                else
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.pressure <= pressure_backlog.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_mode = 0;
            stall_cycle = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (speed_expect.size() == 0)
                begin
                    report_mismatch("no request outstanding", '0);
                end
                else if (speed_expect[0].speed !== result_ch.speed ||
                         speed_expect[0].saturated !== result_ch.saturated)
                begin
                    report_mismatch("field", speed_expect.pop_front());
                end
                else
                begin
                    void'(speed_expect.pop_front());
                end
            end
            stall_cycle++;
            if (stall_cycle % 50 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= (stall_cycle % 7 < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int phase;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.pressure = '0;
        result_ch.ready = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        for (i = 0; i < NUM_CAL; i++)
        begin
            cal_speed[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Steep drop at the top: negative results, overflow and quotients that truncate to zero.
        cal_plan = '{16'd30000, 16'd40000, 16'd50000, 16'd65535, 16'd1, 16'd0};
        program_cal();
        for (i = 0; i < 25; i++)
        begin
            pressure_backlog.push_back(EDGE_PRESSURES[i]);
        end
        wait_drained();

        cal_plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        program_cal();
        feed_random(40);
        wait_drained();

        cal_plan = '{16'd8000, 16'd12000, 16'd16000, 16'd20000, 16'd24000, 16'd28000};
        program_cal();
        feed_random(200);
        wait_drained();

        cal_plan = '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
        program_cal();
        feed_random(100);
        wait_drained();

        // The sender holds back halfway until every request of the first half has returned.
        cal_plan = '{16'd65535, 16'd50000, 16'd30000, 16'd10000, 16'd5000, 16'd0};
        program_cal();
        feed_random(75);
        wait_drained();
        feed_random(75);
        wait_drained();

        cal_plan = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535};
        program_cal();
        feed_random(150);
        wait_drained();

        for (phase = 0; phase < 6; phase++)
        begin
            random_plan();
            program_cal();
            feed_random(110);
            wait_drained();
        end

        repeat (END_PAD) @(posedge clk);
        if (mismatch_count == 0 && speed_expect.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
